// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the response recognizer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- rtl/arr_pkg.sv -----
// ---------------------------------------------------------------------------
// arr_pkg
// Types, codes and character constants of the AT response recognizer.
// ---------------------------------------------------------------------------
`default_nettype none

package arr_pkg;

   // field widths
   localparam int ACTION_W  = 2;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 3;
   localparam int TICK_W    = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // capture geometry
   localparam int ECHO_LEN   = 2;
   localparam int TAIL_LEN   = 9;
   localparam int OK_LEN     = 6;
   localparam int ERR_LEN    = 9;
   localparam int COUNT_W    = 4;
   localparam int LINE_CNT_W = 2;

   // defaults
   localparam int LINE_END_TARGET_DEF = 3;
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd50;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_START = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ERROR    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ECHO = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RESP = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 3'd4;

   // register word index
   localparam logic [CSR_ADDR_W-3:0] REG_TIMEOUT = 1'b0;

   // characters
   localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_A_UP = 8'h41;
   localparam logic [BYTE_W-1:0] CH_A_LO = 8'h61;
   localparam logic [BYTE_W-1:0] CH_T_UP = 8'h54;
   localparam logic [BYTE_W-1:0] CH_T_LO = 8'h74;

   localparam logic [BYTE_W-1:0] OK_PAT [0:OK_LEN-1] =
      '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
   localparam logic [BYTE_W-1:0] ERR_PAT [0:ERR_LEN-1] =
      '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};

   // core to output stage
   typedef struct packed {
      logic recording;
      logic emit;
   } core_status_type;

endpackage

`default_nettype wire

// ----- rtl/arr_csr.sv -----
// ---------------------------------------------------------------------------
// arr_csr
// APB-style register port holding the timeout limit.
// ---------------------------------------------------------------------------
`default_nettype none

module arr_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [arr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [arr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [arr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic      [arr_pkg::TICK_W-1:0]       timeout_ticks
);

   logic [arr_pkg::TICK_W-1:0] timeout_ff;
   logic [arr_pkg::TICK_W-1:0] timeout_in;
   logic                       hit_timeout;
   logic                       wr_en;

   // word decode, byte lanes ignored
   assign hit_timeout = (csr_paddr[arr_pkg::CSR_ADDR_W-1:2] == arr_pkg::REG_TIMEOUT);
   assign wr_en       = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready  = 1'b1;

   // next value of the limit
   always_comb begin
      timeout_in = timeout_ff;
      if (wr_en && hit_timeout) begin
         timeout_in = csr_pwdata[arr_pkg::TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= arr_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // read mux
   always_comb begin
      csr_prdata = '0;
      if (hit_timeout) begin
         csr_prdata = {{(arr_pkg::CSR_DATA_W-arr_pkg::TICK_W){1'b0}}, timeout_ff};
      end
   end

   assign timeout_ticks = timeout_ff;

endmodule

`default_nettype wire

// ----- rtl/arr_core.sv -----
// ---------------------------------------------------------------------------
// arr_core
// Capture state and response decision, updated once per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module arr_core #(
   parameter int LINE_END_TARGET = arr_pkg::LINE_END_TARGET_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              accept,
   input  wire logic [arr_pkg::ACTION_W-1:0]      action,
   input  wire logic [arr_pkg::BYTE_W-1:0]        rx_byte,
   input  wire logic [arr_pkg::TICK_W-1:0]        timeout_ticks,
   output arr_pkg::core_status_type               core_sts,
   output logic      [arr_pkg::STATUS_W-1:0]      emit_status
);

   localparam int ECHO_IDX_W = $clog2(arr_pkg::ECHO_LEN);
   localparam logic [arr_pkg::LINE_CNT_W-1:0] TARGET = arr_pkg::LINE_CNT_W'(LINE_END_TARGET);
   localparam logic [arr_pkg::LINE_CNT_W-1:0] LINE_MAX = '1;
   localparam logic [arr_pkg::COUNT_W-1:0] COUNT_MAX = arr_pkg::COUNT_W'(arr_pkg::TAIL_LEN);

   logic                             recording_ff, recording_in;
   logic [arr_pkg::BYTE_W-1:0]       echo_ff [arr_pkg::ECHO_LEN];
   logic [arr_pkg::BYTE_W-1:0]       echo_in [arr_pkg::ECHO_LEN];
   logic [arr_pkg::BYTE_W-1:0]       tail_ff [arr_pkg::TAIL_LEN];
   logic [arr_pkg::BYTE_W-1:0]       tail_in [arr_pkg::TAIL_LEN];
   logic [arr_pkg::COUNT_W-1:0]      byte_count_ff, byte_count_in;
   logic [arr_pkg::LINE_CNT_W-1:0]   cr_ff, cr_in;
   logic [arr_pkg::LINE_CNT_W-1:0]   lf_ff, lf_in;
   logic [arr_pkg::TICK_W-1:0]       tick_ff, tick_in;
   logic                             echo_good;
   logic                             ok_match;
   logic                             err_match;
   logic                             emit;
   logic [arr_pkg::STATUS_W-1:0]     status;

   // decision on the updated capture
   always_comb begin
      echo_good = (echo_in[0] == arr_pkg::CH_A_UP || echo_in[0] == arr_pkg::CH_A_LO) &&
                  (echo_in[1] == arr_pkg::CH_T_UP || echo_in[1] == arr_pkg::CH_T_LO);
      ok_match  = (byte_count_in >= arr_pkg::COUNT_W'(arr_pkg::OK_LEN));
      for (int i = 0; i < arr_pkg::OK_LEN; i++) begin
         if (tail_in[arr_pkg::TAIL_LEN-arr_pkg::OK_LEN+i] != arr_pkg::OK_PAT[i]) begin
            ok_match = 1'b0;
         end
      end
      err_match = (byte_count_in >= arr_pkg::COUNT_W'(arr_pkg::ERR_LEN));
      for (int i = 0; i < arr_pkg::ERR_LEN; i++) begin
         if (tail_in[arr_pkg::TAIL_LEN-arr_pkg::ERR_LEN+i] != arr_pkg::ERR_PAT[i]) begin
            err_match = 1'b0;
         end
      end
   end

   // next state and result
   always_comb begin
      recording_in  = recording_ff;
      echo_in       = echo_ff;
      tail_in       = tail_ff;
      byte_count_in = byte_count_ff;
      cr_in         = cr_ff;
      lf_in         = lf_ff;
      tick_in       = tick_ff;
      emit          = 1'b0;
      status        = arr_pkg::STATUS_OK;
      if (accept) begin
         unique case (action)
            arr_pkg::ACT_START: begin
               recording_in  = 1'b1;
               for (int i = 0; i < arr_pkg::ECHO_LEN; i++) echo_in[i] = '0;
               for (int i = 0; i < arr_pkg::TAIL_LEN; i++) tail_in[i] = '0;
               byte_count_in = '0;
               cr_in         = '0;
               lf_in         = '0;
               tick_in       = '0;
            end
            arr_pkg::ACT_BYTE: begin
               if (recording_ff) begin
                  if (byte_count_ff < arr_pkg::COUNT_W'(arr_pkg::ECHO_LEN)) begin
                     echo_in[byte_count_ff[ECHO_IDX_W-1:0]] = rx_byte;
                  end
                  for (int i = 0; i < arr_pkg::TAIL_LEN-1; i++) tail_in[i] = tail_ff[i+1];
                  tail_in[arr_pkg::TAIL_LEN-1] = rx_byte;
                  if (byte_count_ff < COUNT_MAX) begin
                     byte_count_in = byte_count_ff + 1'b1;
                  end
                  if (rx_byte == arr_pkg::CH_CR) begin
                     if (cr_ff != LINE_MAX) cr_in = cr_ff + 1'b1;
                  end else if (rx_byte == arr_pkg::CH_LF) begin
                     if (lf_ff != LINE_MAX) lf_in = lf_ff + 1'b1;
                  end
                  if (cr_in >= TARGET && lf_in >= TARGET) begin
                     emit         = 1'b1;
                     recording_in = 1'b0;
                     if (!echo_good) begin
                        status = arr_pkg::STATUS_BAD_ECHO;
                     end else if (ok_match) begin
                        status = arr_pkg::STATUS_OK;
                     end else if (err_match) begin
                        status = arr_pkg::STATUS_ERROR;
                     end else begin
                        status = arr_pkg::STATUS_BAD_RESP;
                     end
                  end
               end
            end
            arr_pkg::ACT_TICK: begin
               if (recording_ff) begin
                  if (tick_ff != '1) tick_in = tick_ff + 1'b1;
                  if (tick_in > timeout_ticks) begin
                     emit         = 1'b1;
                     recording_in = 1'b0;
                     status       = arr_pkg::STATUS_TIMEOUT;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         recording_ff  <= 1'b0;
         byte_count_ff <= '0;
         cr_ff         <= '0;
         lf_ff         <= '0;
         tick_ff       <= '0;
      end else begin
         recording_ff  <= recording_in;
         byte_count_ff <= byte_count_in;
         cr_ff         <= cr_in;
         lf_ff         <= lf_in;
         tick_ff       <= tick_in;
      end
   end

   // captured bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arr_pkg::ECHO_LEN; i++) echo_ff[i] <= '0;
         for (int i = 0; i < arr_pkg::TAIL_LEN; i++) tail_ff[i] <= '0;
      end else begin
         echo_ff <= echo_in;
         tail_ff <= tail_in;
      end
   end

   assign core_sts.recording = recording_ff;
   assign core_sts.emit      = emit;
   assign emit_status        = status;

endmodule

`default_nettype wire

// ----- rtl/arr_out.sv -----
// ---------------------------------------------------------------------------
// arr_out
// Result register with valid/stall handshake and input back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module arr_out (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire arr_pkg::core_status_type        core_sts,
   input  wire logic [arr_pkg::STATUS_W-1:0]    emit_status,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid,
   output logic      [arr_pkg::STATUS_W-1:0]    rsp_status,
   output logic                                 req_stall
);

   logic                          valid_ff, valid_in;
   logic [arr_pkg::STATUS_W-1:0]  status_ff, status_in;

   // input waits only while a held result is stalled
   assign req_stall = valid_ff & rsp_stall;

   always_comb begin
      valid_in  = valid_ff;
      status_in = status_ff;
      if (core_sts.emit) begin
         valid_in  = 1'b1;
         status_in = emit_status;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// ----- rtl/at_response_recognizer.sv -----
// ---------------------------------------------------------------------------
// at_response_recognizer
// Recognizes a modem's reply to one AT command and reports its status.
// ---------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_action, req_rx_byte
//  rsp      out        rsp_valid / rsp_stall  rsp_status
//  csr      in/out     APB psel/penable       timeout_ticks at byte address 0
//
//  One transaction per cycle while req_stall is low; a status appears on rsp in
//  the cycle after the transaction that completes a response or a timeout.
//  The capture state and the decision logic form one stage ahead of the
//  result register.
//  req_stall is high only while a result is held and rsp_stall is high.
//  Reset is synchronous; the block is ready in the cycle after reset.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module at_response_recognizer #(
   parameter int LINE_END_TARGET = arr_pkg::LINE_END_TARGET_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [arr_pkg::ACTION_W-1:0]     req_action,
   input  wire logic [arr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [arr_pkg::STATUS_W-1:0]     rsp_status,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [arr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [arr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [arr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [arr_pkg::TICK_W-1:0]    timeout_ticks;
   logic                          req_accept;
   arr_pkg::core_status_type      core_sts;
   logic [arr_pkg::STATUS_W-1:0]  emit_status;

   assign req_accept = req_valid & ~req_stall;

   // configuration register
   arr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .timeout_ticks (timeout_ticks)
   );

   // capture and decision
   arr_core #(
      .LINE_END_TARGET (LINE_END_TARGET)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .action        (req_action),
      .rx_byte       (req_rx_byte),
      .timeout_ticks (timeout_ticks),
      .core_sts      (core_sts),
      .emit_status   (emit_status)
   );

   // result register
   arr_out u_out (
      .clock       (clock),
      .reset       (reset),
      .core_sts    (core_sts),
      .emit_status (emit_status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_status  (rsp_status),
      .req_stall   (req_stall)
   );

   // checks
   `ASSERT_NEXT(a_start_records, clock, reset,
      req_accept && req_action == arr_pkg::ACT_START, core_sts.recording)
   `ASSERT_NEXT(a_emit_stops, clock, reset, core_sts.emit, !core_sts.recording && rsp_valid)
   `ASSERT_SAME(a_stall_held, clock, reset, req_stall, rsp_valid && !core_sts.emit)

endmodule

`default_nettype wire
